// ===== rtl/core/vang_pkg.sv =====
// Shared types, constants and a helper function for the vector angle block.
// No dependencies; compiled first.
package vang_pkg;

    localparam int COORD_W       = 32;   // input coordinate width, Q15.16
    localparam int ANGLE_W       = 24;   // result angle width
    localparam int FRAC_BITS_DEF = 16;
    localparam int SCL_W         = 16;   // block-scaled component width
    localparam int DIV_W         = 32;   // root and |dot| width
    localparam int QUO_W         = 31;   // cosine quotient width, Q1.30 up to 2^30
    localparam int SQ1_W         = 64;   // radicand width, |a|^2 |b|^2
    localparam int SQ2_W         = 62;   // radicand width, 1 - cos^2
    localparam int CORDIC_STEPS  = 30;
    localparam int CORDIC_W      = 34;
    localparam int DEG_HALF_TURN = 180;

    localparam logic [31:0] PI_Q30          = 32'd3373259426;
    localparam logic [31:0] HALF_PI_Q30     = 32'd1686629713;
    localparam logic [31:0] DEG_PER_RAD_Q26 = 32'd3845054675;
    localparam logic [QUO_W-1:0] ONE_Q30    = QUO_W'(1) << 30;

    localparam logic [29:0] ATAN_TAB [10] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
        30'd33543516,  30'd16775851,  30'd8388437,   30'd4194283,   30'd2097149
    };

    // per-word flags carried down the pipe
    typedef struct packed {
        logic zero;   // a or b is the null vector
        logic dep;    // a and b are linearly dependent
        logic anti;   // dependent and pointing opposite ways
        logic neg;    // dot product negative
    } vang_side_t;

    // atan(2^-step) in Q2.30, rounded to nearest
    function automatic logic [29:0] atan_q30(input int step);
        if (step < 10)
            return ATAN_TAB[4'(step)];
        return 30'(1) << (30 - step);
    endfunction

endpackage

// ===== rtl/core/vang_ifs.sv =====
// Valid/ready channel interfaces for the vector angle block.
// Depends on vang_pkg.
interface vang_in_if;
    import vang_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] a_x;
    logic signed [COORD_W-1:0] a_y;
    logic signed [COORD_W-1:0] a_z;
    logic signed [COORD_W-1:0] b_x;
    logic signed [COORD_W-1:0] b_y;
    logic signed [COORD_W-1:0] b_z;
    modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, input ready);
    modport sink   (input valid, a_x, a_y, a_z, b_x, b_y, b_z, output ready);
endinterface

interface vang_out_if;
    import vang_pkg::*;
    logic               valid;
    logic               ready;
    logic [ANGLE_W-1:0] angle;
    logic               status;
    modport source (output valid, angle, status, input ready);
    modport sink   (input valid, angle, status, output ready);
endinterface

// ===== rtl/core/vang_sqrt_cell.sv =====
// One digit step of a pipelined integer square root (floor).
// Depends on vang_pkg.
module vang_sqrt_cell #(
    parameter int W     = 64,
    parameter int STEP  = 0,
    parameter int AUX_W = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [W-1:0]           in_v,
    input  logic [W-1:0]           in_r,
    input  logic [AUX_W-1:0]       in_aux,
    input  vang_pkg::vang_side_t   in_side,
    output logic                   out_valid,
    output logic [W-1:0]           out_v,
    output logic [W-1:0]           out_r,
    output logic [AUX_W-1:0]       out_aux,
    output vang_pkg::vang_side_t   out_side
);
    import vang_pkg::*;

    localparam logic [W-1:0] BIT = W'(1) << (W - 2 - 2 * STEP);

    logic             valid_reg;
    logic [W-1:0]     v_reg, v_next;
    logic [W-1:0]     r_reg, r_next;
    logic [AUX_W-1:0] aux_reg;
    vang_side_t       side_reg;
    logic [W:0]       trial;
    logic             ge;

    assign trial = {1'b0, in_r} + {1'b0, BIT};
    assign ge    = {1'b0, in_v} >= trial;

    always_comb
    begin
        if (ge)
        begin
            v_next = in_v - trial[W-1:0];
            r_next = (in_r >> 1) + BIT;
        end
        else
        begin
            v_next = in_v;
            r_next = in_r >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg    <= v_next;
            r_reg    <= r_next;
            aux_reg  <= in_aux;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_v     = v_reg;
    assign out_r     = r_reg;
    assign out_aux   = aux_reg;
    assign out_side  = side_reg;

endmodule

// ===== rtl/core/vang_div_cell.sv =====
// One quotient bit of a pipelined restoring divider (remainder below divisor).
// Depends on vang_pkg.
module vang_div_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [vang_pkg::DIV_W-1:0]  in_s,
    input  logic [vang_pkg::DIV_W-1:0]  in_r,
    input  logic [vang_pkg::QUO_W-1:0]  in_q,
    input  vang_pkg::vang_side_t        in_side,
    output logic                        out_valid,
    output logic [vang_pkg::DIV_W-1:0]  out_s,
    output logic [vang_pkg::DIV_W-1:0]  out_r,
    output logic [vang_pkg::QUO_W-1:0]  out_q,
    output vang_pkg::vang_side_t        out_side
);
    import vang_pkg::*;

    logic             valid_reg;
    logic [DIV_W-1:0] s_reg;
    logic [DIV_W-1:0] r_reg, r_next;
    logic [QUO_W-1:0] q_reg, q_next;
    vang_side_t       side_reg;
    logic [DIV_W:0]   t;
    logic             ge;

    assign t  = {in_r, 1'b0};
    assign ge = t >= {1'b0, in_s};

    always_comb
    begin
        r_next = ge ? DIV_W'(t - {1'b0, in_s}) : t[DIV_W-1:0];
        q_next = {in_q[QUO_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg    <= in_s;
            r_reg    <= r_next;
            q_reg    <= q_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_s     = s_reg;
    assign out_r     = r_reg;
    assign out_q     = q_reg;
    assign out_side  = side_reg;

endmodule

// ===== rtl/core/vang_cordic_cell.sv =====
// One CORDIC vectoring rotation; accumulates the arc angle in Q2.30.
// Depends on vang_pkg.
module vang_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic signed [vang_pkg::CORDIC_W-1:0] in_x,
    input  logic signed [vang_pkg::CORDIC_W-1:0] in_y,
    input  logic signed [vang_pkg::CORDIC_W-1:0] in_z,
    input  vang_pkg::vang_side_t                in_side,
    output logic                                out_valid,
    output logic signed [vang_pkg::CORDIC_W-1:0] out_x,
    output logic signed [vang_pkg::CORDIC_W-1:0] out_y,
    output logic signed [vang_pkg::CORDIC_W-1:0] out_z,
    output vang_pkg::vang_side_t                out_side
);
    import vang_pkg::*;

    localparam logic signed [CORDIC_W-1:0] T = signed'(CORDIC_W'(atan_q30(STEP)));

    logic                       valid_reg;
    logic signed [CORDIC_W-1:0] x_reg, x_next;
    logic signed [CORDIC_W-1:0] y_reg, y_next;
    logic signed [CORDIC_W-1:0] z_reg, z_next;
    vang_side_t                 side_reg;
    logic signed [CORDIC_W-1:0] xs, ys;

    // arithmetic shift: floors negative values
    assign xs = in_x >>> STEP;
    assign ys = in_y >>> STEP;

    always_comb
    begin
        if (in_y > 0)
        begin
            x_next = in_x + ys;
            y_next = in_y - xs;
            z_next = in_z + T;
        end
        else
        begin
            x_next = in_x - ys;
            y_next = in_y + xs;
            z_next = in_z - T;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_side  = side_reg;

endmodule

// ===== rtl/core/vector_angle_3d.sv =====
// Angle between two 3D vectors given as signed Q15.16 coordinates, returned as
// unsigned Q.FRAC_BITS in degrees (angle_unit = 1, the reset value) or radians
// (angle_unit = 0). Fully pipelined: one vector pair is taken every clock while
// the skid entry is empty, and the pipe holds while it is full. A word passes
// through the 136 register stages of the cell chains: 7 front-end stages
// (dependency test, block scaling, dot product and squared lengths), 32 root
// cells for |a||b|, 1 + 30 divider cells for the cosine, 2 stages and 31 root
// cells for the sine, 30 CORDIC cells for the arc, 2 unit-conversion stages
// and the output register. A null input vector gives status 1 and angle 0;
// parallel vectors give 0 and antiparallel vectors 180 degrees or pi exactly. A
// two-entry output buffer keeps input ready independent of the output ready in
// the same cycle. angle_unit should only be written while no pair is in flight.
// Depends on vang_pkg, vang_ifs, vang_sqrt_cell, vang_div_cell, vang_cordic_cell.
module vector_angle_3d #(
    parameter int FRAC_BITS = vang_pkg::FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_wdata,
    vang_in_if.sink      vec_in,
    vang_out_if.source   angle_out
);
    import vang_pkg::*;

    // output scaling
    localparam int          RAD_SH   = 30 - FRAC_BITS;
    localparam logic [63:0] RAD_RND  = 64'(1) << (29 - FRAC_BITS);
    localparam int          DEG_SH   = 56 - FRAC_BITS;
    localparam logic [63:0] DEG_RND  = 64'(1) << (55 - FRAC_BITS);
    localparam logic [63:0] ANG_MAX  = 64'(2 ** ANGLE_W - 1);
    localparam logic [63:0] PI_RAD   = (64'(PI_Q30) + RAD_RND) >> RAD_SH;
    localparam logic [63:0] DEG_180  = 64'(DEG_HALF_TURN) << FRAC_BITS;
    localparam logic [ANGLE_W-1:0] ANTI_RAD =
        ANGLE_W'((PI_RAD > ANG_MAX) ? ANG_MAX : PI_RAD);
    localparam logic [ANGLE_W-1:0] ANTI_DEG =
        ANGLE_W'((DEG_180 > ANG_MAX) ? ANG_MAX : DEG_180);

    localparam int SQ1_N = SQ1_W / 2;
    localparam int SQ2_N = SQ2_W / 2;
    localparam int DIV_N = QUO_W - 1;
    localparam logic [SQ2_W-1:0] ONE_SQ = SQ2_W'(1) << 60;

    // ---------------------------------------------------------------- helpers
    function automatic logic [COORD_W-1:0] mag32(input logic signed [COORD_W-1:0] v);
        return v[COORD_W-1] ? COORD_W'(-v) : COORD_W'(v);
    endfunction

    function automatic logic [COORD_W-1:0] max3(input logic [COORD_W-1:0] p,
                                                input logic [COORD_W-1:0] q,
                                                input logic [COORD_W-1:0] r);
        logic [COORD_W-1:0] m;
        m = (p > q) ? p : q;
        return (r > m) ? r : m;
    endfunction

    // number of significant bits, 0 .. 32
    function automatic logic [5:0] bit_len(input logic [COORD_W-1:0] m);
        logic [5:0] n;
        n = '0;
        for (int i = 0; i < COORD_W; i++)
            if (m[i])
                n = 6'(i + 1);
        return n;
    endfunction

    // block scaling: largest magnitude lands in [2^14, 2^15]
    function automatic logic signed [SCL_W-1:0] scale(input logic signed [COORD_W-1:0] v,
                                                      input logic [5:0] len);
        logic signed [COORD_W-1:0] t;
        if (len >= 6'd15)
            t = v >>> (len - 6'd15);
        else
            t = v <<< (6'd15 - len);
        return t[SCL_W-1:0];
    endfunction

    // ---------------------------------------------------------------- control
    logic angle_unit_reg;
    logic en;
    logic skid_valid_reg, skid_valid_next;
    logic out_valid_reg, out_valid_next;

    // the pipe moves whenever the skid entry is free
    assign en           = !skid_valid_reg;
    assign vec_in.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            angle_unit_reg <= 1'b1;
        else if (cfg_we)
            angle_unit_reg <= cfg_wdata;
    end

    // ---------------------------------------------------------------- S1: cross products
    logic signed [COORD_W-1:0] in_a [3];
    logic signed [COORD_W-1:0] in_b [3];
    logic signed [63:0]        p_next [6];

    assign in_a[0] = vec_in.a_x;
    assign in_a[1] = vec_in.a_y;
    assign in_a[2] = vec_in.a_z;
    assign in_b[0] = vec_in.b_x;
    assign in_b[1] = vec_in.b_y;
    assign in_b[2] = vec_in.b_z;

    assign p_next[0] = in_a[0] * in_b[1];
    assign p_next[1] = in_b[0] * in_a[1];
    assign p_next[2] = in_a[0] * in_b[2];
    assign p_next[3] = in_b[0] * in_a[2];
    assign p_next[4] = in_a[1] * in_b[2];
    assign p_next[5] = in_b[1] * in_a[2];

    logic                      s1_valid_reg;
    logic signed [COORD_W-1:0] s1_a_reg [3];
    logic signed [COORD_W-1:0] s1_b_reg [3];
    logic signed [63:0]        s1_p_reg [6];
    logic                      s1_za_reg, s1_zb_reg;

    // ---------------------------------------------------------------- S2: dependency, maxima
    logic                      s2_valid_reg;
    logic signed [COORD_W-1:0] s2_a_reg [3];
    logic signed [COORD_W-1:0] s2_b_reg [3];
    logic [COORD_W-1:0]        s2_ma_reg, s2_mb_reg;
    vang_side_t                s2_side_reg, s2_side_next;

    always_comb
    begin
        s2_side_next.zero = s1_za_reg || s1_zb_reg;
        s2_side_next.dep  = (s1_p_reg[0] == s1_p_reg[1]) && (s1_p_reg[2] == s1_p_reg[3])
                         && (s1_p_reg[4] == s1_p_reg[5]);
        // sign test on the first non-zero component of a
        if (s1_a_reg[0] != '0)
            s2_side_next.anti = s1_a_reg[0][COORD_W-1] ^ s1_b_reg[0][COORD_W-1];
        else if (s1_a_reg[1] != '0)
            s2_side_next.anti = s1_a_reg[1][COORD_W-1] ^ s1_b_reg[1][COORD_W-1];
        else
            s2_side_next.anti = s1_a_reg[2][COORD_W-1] ^ s1_b_reg[2][COORD_W-1];
        s2_side_next.neg  = 1'b0;
    end

    // ---------------------------------------------------------------- S3: exponent
    logic                      s3_valid_reg;
    logic signed [COORD_W-1:0] s3_a_reg [3];
    logic signed [COORD_W-1:0] s3_b_reg [3];
    logic [5:0]                s3_la_reg, s3_lb_reg;
    vang_side_t                s3_side_reg;

    // ---------------------------------------------------------------- S4: scaled vectors
    logic                    s4_valid_reg;
    logic signed [SCL_W-1:0] s4_sa_reg [3];
    logic signed [SCL_W-1:0] s4_sb_reg [3];
    vang_side_t              s4_side_reg;

    // ---------------------------------------------------------------- S5: products
    logic               s5_valid_reg;
    logic signed [31:0] s5_dp_reg [3];
    logic signed [31:0] s5_qa_reg [3];
    logic signed [31:0] s5_qb_reg [3];
    vang_side_t         s5_side_reg;

    // ---------------------------------------------------------------- S6: sums
    logic               s6_valid_reg;
    logic signed [33:0] s6_d_reg, s6_d_next;
    logic [31:0]        s6_la_reg, s6_lb_reg;
    logic signed [33:0] la_sum, lb_sum;
    vang_side_t         s6_side_reg;

    assign s6_d_next = 34'(s5_dp_reg[0]) + 34'(s5_dp_reg[1]) + 34'(s5_dp_reg[2]);
    assign la_sum    = 34'(s5_qa_reg[0]) + 34'(s5_qa_reg[1]) + 34'(s5_qa_reg[2]);
    assign lb_sum    = 34'(s5_qb_reg[0]) + 34'(s5_qb_reg[1]) + 34'(s5_qb_reg[2]);

    // ---------------------------------------------------------------- S7: |a|^2 |b|^2
    logic             s7_valid_reg;
    logic [SQ1_W-1:0] s7_l_reg, s7_l_next;
    logic [DIV_W-1:0] s7_mag_reg;
    vang_side_t       s7_side_reg, s7_side_next;

    assign s7_l_next = s6_la_reg * s6_lb_reg;

    always_comb
    begin
        s7_side_next     = s6_side_reg;
        s7_side_next.neg = s6_d_reg[33];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= vec_in.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_a_reg    <= in_a;
            s1_b_reg    <= in_b;
            s1_p_reg    <= p_next;
            s1_za_reg   <= (in_a[0] == '0) && (in_a[1] == '0) && (in_a[2] == '0);
            s1_zb_reg   <= (in_b[0] == '0) && (in_b[1] == '0) && (in_b[2] == '0);

            s2_a_reg    <= s1_a_reg;
            s2_b_reg    <= s1_b_reg;
            s2_ma_reg   <= max3(mag32(s1_a_reg[0]), mag32(s1_a_reg[1]), mag32(s1_a_reg[2]));
            s2_mb_reg   <= max3(mag32(s1_b_reg[0]), mag32(s1_b_reg[1]), mag32(s1_b_reg[2]));
            s2_side_reg <= s2_side_next;

            s3_a_reg    <= s2_a_reg;
            s3_b_reg    <= s2_b_reg;
            s3_la_reg   <= bit_len(s2_ma_reg);
            s3_lb_reg   <= bit_len(s2_mb_reg);
            s3_side_reg <= s2_side_reg;

            for (int i = 0; i < 3; i++)
            begin
                s4_sa_reg[i] <= scale(s3_a_reg[i], s3_la_reg);
                s4_sb_reg[i] <= scale(s3_b_reg[i], s3_lb_reg);
                s5_dp_reg[i] <= s4_sa_reg[i] * s4_sb_reg[i];
                s5_qa_reg[i] <= s4_sa_reg[i] * s4_sa_reg[i];
                s5_qb_reg[i] <= s4_sb_reg[i] * s4_sb_reg[i];
            end
            s4_side_reg <= s3_side_reg;
            s5_side_reg <= s4_side_reg;

            s6_d_reg    <= s6_d_next;
            s6_la_reg   <= la_sum[31:0];
            s6_lb_reg   <= lb_sum[31:0];
            s6_side_reg <= s5_side_reg;

            s7_l_reg    <= s7_l_next;
            s7_mag_reg  <= s6_d_reg[33] ? DIV_W'(-s6_d_reg) : DIV_W'(s6_d_reg);
            s7_side_reg <= s7_side_next;
        end
    end

    // ---------------------------------------------------------------- root of |a|^2 |b|^2
    logic             sq1_vld  [0:SQ1_N];
    logic [SQ1_W-1:0] sq1_v    [0:SQ1_N];
    logic [SQ1_W-1:0] sq1_r    [0:SQ1_N];
    logic [DIV_W-1:0] sq1_aux  [0:SQ1_N];
    vang_side_t       sq1_side [0:SQ1_N];

    assign sq1_vld[0]  = s7_valid_reg;
    assign sq1_v[0]    = s7_l_reg;
    assign sq1_r[0]    = '0;
    assign sq1_aux[0]  = s7_mag_reg;
    assign sq1_side[0] = s7_side_reg;

    for (genvar i = 0; i < SQ1_N; i++)
    begin : g_sq1
        vang_sqrt_cell #(.W(SQ1_W), .STEP(i), .AUX_W(DIV_W)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (sq1_vld[i]),
            .in_v      (sq1_v[i]),
            .in_r      (sq1_r[i]),
            .in_aux    (sq1_aux[i]),
            .in_side   (sq1_side[i]),
            .out_valid (sq1_vld[i+1]),
            .out_v     (sq1_v[i+1]),
            .out_r     (sq1_r[i+1]),
            .out_aux   (sq1_aux[i+1]),
            .out_side  (sq1_side[i+1])
        );
    end

    // ---------------------------------------------------------------- D0: top quotient bit
    // |dot| never exceeds the root, so one compare settles bit 30
    logic             d0_valid_reg;
    logic [DIV_W-1:0] d0_s_reg, d0_r_reg, s_root, mag;
    logic [QUO_W-1:0] d0_q_reg;
    vang_side_t       d0_side_reg;
    logic             q_top;

    assign s_root = sq1_r[SQ1_N][DIV_W-1:0];
    assign mag    = sq1_aux[SQ1_N];
    assign q_top  = mag >= s_root;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d0_valid_reg <= 1'b0;
        else if (en)
            d0_valid_reg <= sq1_vld[SQ1_N];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d0_s_reg    <= s_root;
            d0_r_reg    <= q_top ? mag - s_root : mag;
            d0_q_reg    <= QUO_W'(q_top);
            d0_side_reg <= sq1_side[SQ1_N];
        end
    end

    // ---------------------------------------------------------------- cosine divider
    logic             dv_vld  [0:DIV_N];
    logic [DIV_W-1:0] dv_s    [0:DIV_N];
    logic [DIV_W-1:0] dv_r    [0:DIV_N];
    logic [QUO_W-1:0] dv_q    [0:DIV_N];
    vang_side_t       dv_side [0:DIV_N];

    assign dv_vld[0]  = d0_valid_reg;
    assign dv_s[0]    = d0_s_reg;
    assign dv_r[0]    = d0_r_reg;
    assign dv_q[0]    = d0_q_reg;
    assign dv_side[0] = d0_side_reg;

    for (genvar i = 0; i < DIV_N; i++)
    begin : g_div
        vang_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (dv_vld[i]),
            .in_s      (dv_s[i]),
            .in_r      (dv_r[i]),
            .in_q      (dv_q[i]),
            .in_side   (dv_side[i]),
            .out_valid (dv_vld[i+1]),
            .out_s     (dv_s[i+1]),
            .out_r     (dv_r[i+1]),
            .out_q     (dv_q[i+1]),
            .out_side  (dv_side[i+1])
        );
    end

    // ---------------------------------------------------------------- C0/C1: 1 - cos^2
    // a zero root gives an all-ones quotient, which the clamp turns into 1.0
    logic             c0_valid_reg, c1_valid_reg;
    logic [QUO_W-1:0] c0_c_reg, c1_c_reg, c_clamp;
    logic [SQ2_W-1:0] c0_cc_reg, c0_cc_next, c1_v_reg;
    vang_side_t       c0_side_reg, c1_side_reg;

    assign c_clamp    = (dv_q[DIV_N] > ONE_Q30) ? ONE_Q30 : dv_q[DIV_N];
    assign c0_cc_next = c_clamp * c_clamp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c0_valid_reg <= 1'b0;
            c1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            c0_valid_reg <= dv_vld[DIV_N];
            c1_valid_reg <= c0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c0_c_reg    <= c_clamp;
            c0_cc_reg   <= c0_cc_next;
            c0_side_reg <= dv_side[DIV_N];
            c1_c_reg    <= c0_c_reg;
            c1_v_reg    <= ONE_SQ - c0_cc_reg;
            c1_side_reg <= c0_side_reg;
        end
    end

    // ---------------------------------------------------------------- sine root
    logic             sq2_vld  [0:SQ2_N];
    logic [SQ2_W-1:0] sq2_v    [0:SQ2_N];
    logic [SQ2_W-1:0] sq2_r    [0:SQ2_N];
    logic [QUO_W-1:0] sq2_aux  [0:SQ2_N];
    vang_side_t       sq2_side [0:SQ2_N];

    assign sq2_vld[0]  = c1_valid_reg;
    assign sq2_v[0]    = c1_v_reg;
    assign sq2_r[0]    = '0;
    assign sq2_aux[0]  = c1_c_reg;
    assign sq2_side[0] = c1_side_reg;

    for (genvar i = 0; i < SQ2_N; i++)
    begin : g_sq2
        vang_sqrt_cell #(.W(SQ2_W), .STEP(i), .AUX_W(QUO_W)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (sq2_vld[i]),
            .in_v      (sq2_v[i]),
            .in_r      (sq2_r[i]),
            .in_aux    (sq2_aux[i]),
            .in_side   (sq2_side[i]),
            .out_valid (sq2_vld[i+1]),
            .out_v     (sq2_v[i+1]),
            .out_r     (sq2_r[i+1]),
            .out_aux   (sq2_aux[i+1]),
            .out_side  (sq2_side[i+1])
        );
    end

    // ---------------------------------------------------------------- CORDIC arc
    logic                       cd_vld  [0:CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] cd_x    [0:CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] cd_y    [0:CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] cd_z    [0:CORDIC_STEPS];
    vang_side_t                 cd_side [0:CORDIC_STEPS];

    assign cd_vld[0]  = sq2_vld[SQ2_N];
    assign cd_x[0]    = signed'(CORDIC_W'(sq2_aux[SQ2_N]));
    assign cd_y[0]    = signed'(CORDIC_W'(sq2_r[SQ2_N][QUO_W-1:0]));
    assign cd_z[0]    = '0;
    assign cd_side[0] = sq2_side[SQ2_N];

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        vang_cordic_cell #(.STEP(i)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (cd_vld[i]),
            .in_x      (cd_x[i]),
            .in_y      (cd_y[i]),
            .in_z      (cd_z[i]),
            .in_side   (cd_side[i]),
            .out_valid (cd_vld[i+1]),
            .out_x     (cd_x[i+1]),
            .out_y     (cd_y[i+1]),
            .out_z     (cd_z[i+1]),
            .out_side  (cd_side[i+1])
        );
    end

    // ---------------------------------------------------------------- F1: theta
    logic                       f1_valid_reg;
    logic [31:0]                f1_theta_reg, z_clamp;
    vang_side_t                 f1_side_reg;
    logic signed [CORDIC_W-1:0] z_end;

    assign z_end = cd_z[CORDIC_STEPS];

    always_comb
    begin
        if (z_end < 0)
            z_clamp = '0;
        else if (z_end > signed'(CORDIC_W'(HALF_PI_Q30)))
            z_clamp = HALF_PI_Q30;
        else
            z_clamp = z_end[31:0];
    end

    // ---------------------------------------------------------------- F2: unit scaling
    logic               f2_valid_reg;
    logic [63:0]        f2_deg_reg, f2_deg_next;
    logic [32:0]        f2_rad_reg, f2_rad_next;
    vang_side_t         f2_side_reg;

    assign f2_deg_next = f1_theta_reg * DEG_PER_RAD_Q26;
    assign f2_rad_next = (33'(f1_theta_reg) + 33'(RAD_RND)) >> RAD_SH;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            f1_valid_reg <= cd_vld[CORDIC_STEPS];
            f2_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_theta_reg <= cd_side[CORDIC_STEPS].neg ? PI_Q30 - z_clamp : z_clamp;
            f1_side_reg  <= cd_side[CORDIC_STEPS];
            f2_deg_reg   <= f2_deg_next;
            f2_rad_reg   <= f2_rad_next;
            f2_side_reg  <= f1_side_reg;
        end
    end

    // ---------------------------------------------------------------- result word
    logic [63:0]        deg_val, any_val;
    logic [ANGLE_W-1:0] res_angle;
    logic               res_status;

    always_comb
    begin
        deg_val = (f2_deg_reg + DEG_RND) >> DEG_SH;
        any_val = angle_unit_reg ? deg_val : 64'(f2_rad_reg);
        res_status = 1'b0;
        if (f2_side_reg.zero)
        begin
            res_angle  = '0;
            res_status = 1'b1;
        end
        else if (f2_side_reg.dep)
        begin
            if (f2_side_reg.anti)
                res_angle = angle_unit_reg ? ANTI_DEG : ANTI_RAD;
            else
                res_angle = '0;
        end
        else
            res_angle = ANGLE_W'((any_val > ANG_MAX) ? ANG_MAX : any_val);
    end

    // ---------------------------------------------------------------- output + skid
    logic [ANGLE_W-1:0] out_angle_reg, out_angle_next;
    logic [ANGLE_W-1:0] skid_angle_reg, skid_angle_next;
    logic               out_status_reg, out_status_next;
    logic               skid_status_reg, skid_status_next;

    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_angle_next   = out_angle_reg;
        out_status_next  = out_status_reg;
        skid_valid_next  = skid_valid_reg;
        skid_angle_next  = skid_angle_reg;
        skid_status_next = skid_status_reg;
        if (out_valid_reg && angle_out.ready)
            out_valid_next = 1'b0;
        if (skid_valid_reg)
        begin
            if (!out_valid_next)
            begin
                out_valid_next  = 1'b1;
                out_angle_next  = skid_angle_reg;
                out_status_next = skid_status_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (f2_valid_reg)
        begin
            if (!out_valid_next)
            begin
                out_valid_next  = 1'b1;
                out_angle_next  = res_angle;
                out_status_next = res_status;
            end
            else
            begin
                skid_valid_next  = 1'b1;
                skid_angle_next  = res_angle;
                skid_status_next = res_status;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_angle_reg   <= out_angle_next;
        out_status_reg  <= out_status_next;
        skid_angle_reg  <= skid_angle_next;
        skid_status_reg <= skid_status_next;
    end

    assign angle_out.valid  = out_valid_reg;
    assign angle_out.angle  = out_angle_reg;
    assign angle_out.status = out_status_reg;

    // ---------------------------------------------------------------- checks
    // the skid entry only fills behind a waiting output word
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word without output word");

    // a null-vector word always carries angle 0
    a_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
        (angle_out.valid && angle_out.status) |-> (angle_out.angle == '0))
        else $error("status set with non-zero angle");

    // a word at the pipe end is not dropped while the pipe is held
    a_pipe_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (f2_valid_reg && !en) |=> f2_valid_reg)
        else $error("word lost at pipe end during stall");

endmodule

// ===== test/testbench.sv =====
// Self-checking bench for vector_angle_3d: directed pairs, then random vector pairs
// in both angle units, with random gaps on both channels but in one phase. Depends on vang_pkg and vang_ifs.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import vang_pkg::*;

    localparam int LATENCY    = 135;
    localparam int SETTLE     = LATENCY + 8;   // cycles allowed for the pipe to empty
    localparam int WDOG_LIMIT = 2000;          // cycles with no word moving on either side
    localparam int RAND_WORDS = 300;           // per random phase, three phases

    typedef logic signed [COORD_W-1:0] coord_t;

    // one vector pair as it goes onto the input channel
    typedef struct packed {
        coord_t ax, ay, az;
        coord_t bx, by, bz;
    } pair_t;

    // one word of the output channel
    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic               status;
    } angle_word_t;

    // how a directed row is checked: against the predictor, or a value typed in
    typedef enum logic [1:0] {
        CHK_MODEL,     // predictor
        CHK_NULL,      // a null vector: status 1, angle 0
        CHK_SAME,      // parallel, same way: angle 0
        CHK_OPPOSITE   // antiparallel: exactly 180 degrees
    } chk_kind_t;

    typedef struct packed {
        pair_t     pair;
        chk_kind_t kind;
    } row_t;

    localparam coord_t CMAX = 32'sh7fffffff;
    localparam coord_t CMIN = 32'sh80000000;
    localparam logic [ANGLE_W-1:0] HALF_TURN_DEG = ANGLE_W'(DEG_HALF_TURN) << FRAC_BITS_DEF;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    vang_in_if  vec_ch();
    vang_out_if ang_ch();

    vector_angle_3d DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .vec_in    (vec_ch.sink),
        .angle_out (ang_ch.source)
    );

    // Bench copy of the angle_unit register, updated when we write it.
    logic unit_deg;

    angle_word_t pending_angles[$];   // expected words, oldest first
    int          n_sent;
    int          n_got;
    int          n_bad;
    int          n_null;
    int          idle_cycles;
    bit          no_gaps;             // when set, neither side idles

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor. Integer square root of a 64-bit value, floor.
    // ------------------------------------------------------------------
    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Normalise so the largest magnitude sits in [2^14, 2^15]; right shifts floor.
    function automatic void norm_vec(input longint v[3], output longint o[3]);
        longint unsigned m;
        longint unsigned mag;
        int              len;
        m   = 0;
        len = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
            if (mag > m)
                m = mag;
        end
        while (len < 40 && (m >> len) != 0)
            len++;
        for (int i = 0; i < 3; i++)
            o[i] = (len >= 15) ? (v[i] >>> (len - 15)) : (v[i] <<< (15 - len));
    endfunction

    // Q2.30 angle to the output format in the chosen unit, saturated.
    function automatic logic [ANGLE_W-1:0] q30_to_unit(input longint unsigned th, input bit deg);
        longint unsigned r;
        if (deg)
            r = (th * longint'(DEG_PER_RAD_Q26) + (64'd1 << (55 - FRAC_BITS_DEF)))
                >> (56 - FRAC_BITS_DEF);
        else
            r = (th + (64'd1 << (29 - FRAC_BITS_DEF))) >> (30 - FRAC_BITS_DEF);
        if (r > 64'hffffff)
            r = 64'hffffff;
        return r[ANGLE_W-1:0];
    endfunction

    function automatic angle_word_t pair_angle(input pair_t p, input bit deg);
        longint          a[3];
        longint          b[3];
        longint          sa[3];
        longint          sb[3];
        longint          dot;
        longint          x;
        longint          y;
        longint          z;
        longint          xs;
        longint          ys;
        longint          step_atan;
        longint unsigned la;
        longint unsigned lb;
        longint unsigned root;
        longint unsigned mag;
        longint unsigned cosv;
        longint unsigned sinv;
        longint unsigned th;
        angle_word_t     w;
        int              k;
        a[0] = p.ax; a[1] = p.ay; a[2] = p.az;
        b[0] = p.bx; b[1] = p.by; b[2] = p.bz;
        w = '0;
        if ((a[0] == 0 && a[1] == 0 && a[2] == 0) || (b[0] == 0 && b[1] == 0 && b[2] == 0))
        begin
            w.status = 1'b1;
            return w;
        end
        // exact dependency test: every cross-product term zero
        if (a[0] * b[1] == b[0] * a[1] && a[0] * b[2] == b[0] * a[2]
            && a[1] * b[2] == b[1] * a[2])
        begin
            k = 0;
            while (k < 2 && a[k] == 0)
                k++;
            if ((a[k] < 0) != (b[k] < 0))
                w.angle = deg ? HALF_TURN_DEG : q30_to_unit(longint'(PI_Q30), 1'b0);
            return w;
        end
        norm_vec(a, sa);
        norm_vec(b, sb);
        dot  = sa[0] * sb[0] + sa[1] * sb[1] + sa[2] * sb[2];
        la   = sa[0] * sa[0] + sa[1] * sa[1] + sa[2] * sa[2];
        lb   = sb[0] * sb[0] + sb[1] * sb[1] + sb[2] * sb[2];
        root = floor_root(la * lb);
        mag  = (dot < 0) ? -dot : dot;
        cosv = (root != 0) ? (mag << 30) / root : (64'd1 << 30);
        if (cosv > (64'd1 << 30))
            cosv = 64'd1 << 30;
        sinv = floor_root((64'd1 << 60) - cosv * cosv);
        // CORDIC vectoring on (cos, sin) accumulates the arc
        x = cosv;
        y = sinv;
        z = 0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            step_atan = (i < 10) ? longint'(ATAN_TAB[i]) : (longint'(1) << (30 - i));
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + step_atan;
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - step_atan;
            end
        end
        if (z < 0)
            z = 0;
        if (z > longint'(HALF_PI_Q30))
            z = HALF_PI_Q30;
        th = (dot < 0) ? longint'(PI_Q30) - z : z;
        w.angle = q30_to_unit(th, deg);
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic fail_note(input string what, input angle_word_t exp_w, input angle_word_t got);
        n_bad++;
        if (n_bad <= 10)
            $display("mismatch %s at word %0d: expected angle %0d status %0d, got angle %0d status %0d",
                     what, n_got, exp_w.angle, exp_w.status, got.angle, got.status);
    endtask

    // Drive one pair; the expected word is queued at the edge it is taken.
    task automatic send_pair(input pair_t p, input chk_kind_t kind);
        int          gap;
        angle_word_t w;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            vec_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        vec_ch.valid <= 1'b1;
        vec_ch.a_x   <= p.ax;
        vec_ch.a_y   <= p.ay;
        vec_ch.a_z   <= p.az;
        vec_ch.b_x   <= p.bx;
        vec_ch.b_y   <= p.by;
        vec_ch.b_z   <= p.bz;
        do
            @(posedge clk);
        while (!vec_ch.ready);
        case (kind)
            CHK_NULL:     w = '{angle: '0, status: 1'b1};
            CHK_SAME:     w = '{angle: '0, status: 1'b0};
            CHK_OPPOSITE: w = '{angle: HALF_TURN_DEG, status: 1'b0};
            default:      w = pair_angle(p, unit_deg);
        endcase
        if (w.status)
            n_null++;
        pending_angles.insert(pending_angles.size(), w);
        n_sent++;
    endtask

    // Wait until every expected word is back, then let the pipe empty.
    task automatic drain;
        vec_ch.valid <= 1'b0;
        while (pending_angles.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_unit(input bit deg);
        cfg_we    <= 1'b1;
        cfg_wdata <= deg;
        @(posedge clk);
        cfg_we    <= 1'b0;
        unit_deg   = deg;
    endtask

    function automatic coord_t rand_coord();
        coord_t c;
        c = $urandom;
        // mostly full range, sometimes small magnitudes so normalisation shifts left
        if ($urandom_range(0, 3) == 0)
            c = c >>> $urandom_range(8, 31);
        return c;
    endfunction

    function automatic pair_t rand_pair();
        pair_t  p;
        coord_t k;
        int     sel;
        sel  = $urandom_range(0, 19);
        p.ax = rand_coord(); p.ay = rand_coord(); p.az = rand_coord();
        p.bx = rand_coord(); p.by = rand_coord(); p.bz = rand_coord();
        if (sel == 0)
        begin
            // one null vector
            if ($urandom_range(0, 1))
                {p.ax, p.ay, p.az} = '0;
            else
                {p.bx, p.by, p.bz} = '0;
        end
        else if (sel <= 3)
        begin
            // b a small multiple of a, either sign; some components zeroed
            p.ax = $signed($urandom) >>> 16;
            p.ay = $urandom_range(0, 1) ? $signed($urandom) >>> 16 : 0;
            p.az = $signed($urandom) >>> 16;
            k    = $urandom_range(1, 7);
            if ($urandom_range(0, 1))
                k = -k;
            p.bx = p.ax * k; p.by = p.ay * k; p.bz = p.az * k;
        end
        else if (sel <= 5)
        begin
            // nearly parallel or antiparallel: a tiny nudge on one component
            p.bx = p.ax; p.by = p.ay; p.bz = p.az + $signed($urandom_range(0, 4)) - 2;
            if ($urandom_range(0, 1))
                {p.bx, p.by, p.bz} = {-p.bx, -p.by, -p.bz};
        end
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Output side: random stalls on ready, check each word against the oldest expectation
    // ------------------------------------------------------------------
    initial
    begin
        int stall;
        ang_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                ang_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            ang_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!ang_ch.valid);
        end
    end

    always @(posedge clk)
    begin
        angle_word_t got;
        angle_word_t exp_w;
        if (rst_n && ang_ch.valid && ang_ch.ready)
        begin
            got = '{angle: ang_ch.angle, status: ang_ch.status};
            if (pending_angles.size() == 0)
                fail_note("unexpected word", '0, got);
            else
            begin
                exp_w = pending_angles.pop_front();
                if (got.angle !== exp_w.angle)
                    fail_note("angle", exp_w, got);
                if (got.status !== exp_w.status)
                    fail_note("status", exp_w, got);
            end
            n_got++;
        end
    end

    // Watchdog: any word moving on either side resets the count.
    always @(posedge clk)
    begin
        if ((vec_ch.valid && vec_ch.ready) || (ang_ch.valid && ang_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles, %0d still expected",
                     WDOG_LIMIT, pending_angles.size());
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        row_t rows[$];
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = 1'b0;
        vec_ch.valid = 1'b0;
        vec_ch.a_x   = '0;
        vec_ch.a_y   = '0;
        vec_ch.a_z   = '0;
        vec_ch.b_x   = '0;
        vec_ch.b_y   = '0;
        vec_ch.b_z   = '0;
        unit_deg     = 1'b1;   // register resets to degrees
        no_gaps      = 1'b0;
        n_sent = 0; n_got = 0; n_bad = 0; n_null = 0;
        idle_cycles  = 0;

        // Directed pairs, run in degrees straight out of reset.
        // null vectors
        rows.insert(rows.size(), '{'{0, 0, 0, 1, 2, 3}, CHK_NULL});
        rows.insert(rows.size(), '{'{CMAX, CMIN, 5, 0, 0, 0}, CHK_NULL});
        rows.insert(rows.size(), '{'{0, 0, 0, 0, 0, 0}, CHK_NULL});
        // parallel, same way
        rows.insert(rows.size(), '{'{1, 2, 3, 2, 4, 6}, CHK_SAME});
        rows.insert(rows.size(), '{'{0, 0, CMIN, 0, 0, -1}, CHK_SAME});
        rows.insert(rows.size(), '{'{CMAX, CMAX, CMAX, 1, 1, 1}, CHK_SAME});
        // antiparallel
        rows.insert(rows.size(), '{'{1, 0, 0, -1, 0, 0}, CHK_OPPOSITE});
        rows.insert(rows.size(), '{'{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN}, CHK_OPPOSITE});
        rows.insert(rows.size(), '{'{0, 5, -7, 0, -10, 14}, CHK_OPPOSITE});
        // general angles from the predictor
        rows.insert(rows.size(), '{'{1, 0, 0, 0, 1, 0}, CHK_MODEL});
        rows.insert(rows.size(), '{'{65536, 0, 0, 65536, 65536, 0}, CHK_MODEL});
        rows.insert(rows.size(), '{'{CMAX, 0, 0, 0, CMAX, 0}, CHK_MODEL});
        rows.insert(rows.size(), '{'{CMIN, 1, 0, 1, CMIN, 0}, CHK_MODEL});
        rows.insert(rows.size(), '{'{CMAX, CMIN, CMAX, CMIN, CMAX, 1}, CHK_MODEL});
        rows.insert(rows.size(), '{'{1, 1, 0, -1, 0, 0}, CHK_MODEL});
        rows.insert(rows.size(), '{'{-1, -1, -1, 1, 1, -1}, CHK_MODEL});
        rows.insert(rows.size(), '{'{CMAX, CMAX, CMAX - 1, CMAX, CMAX, CMAX}, CHK_MODEL});
        rows.insert(rows.size(), '{'{CMIN, CMIN, CMIN + 1, CMAX, CMAX, CMAX}, CHK_MODEL});
        rows.insert(rows.size(), '{'{1, 0, 0, CMAX, 1, 0}, CHK_MODEL});

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_pair(rows[i].pair, rows[i].kind);
        drain();

        // Random phases: radians, degrees, radians again with no idling at all.
        for (int ph = 0; ph < 3; ph++)
        begin
            set_unit(ph == 1);
            no_gaps = (ph == 2);
            for (int i = 0; i < RAND_WORDS; i++)
                send_pair(rand_pair(), CHK_MODEL);
            drain();
        end
        // finish back in degrees so the write to one is seen after a zero
        set_unit(1'b1);
        no_gaps = 1'b0;
        for (int i = 0; i < 20; i++)
            send_pair(rand_pair(), CHK_MODEL);
        drain();

        $display("ran %0d vector pairs (%0d with a null vector), %0d angle words checked",
                 n_sent, n_null, n_got);
        $display("units: degrees, radians, degrees, radians, degrees; %0d mismatches", n_bad);
        if (n_bad == 0 && pending_angles.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== vector_angle_3d.f =====
rtl/core/vang_pkg.sv
rtl/core/vang_ifs.sv
rtl/core/vang_sqrt_cell.sv
rtl/core/vang_div_cell.sv
rtl/core/vang_cordic_cell.sv
rtl/core/vector_angle_3d.sv
test/testbench.sv
